>>> sv/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int unsigned DefValueBits = 32;
  localparam int unsigned DefMaxRadix  = 16;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RadixW   = 5;
  localparam int unsigned CharW    = 8;

  localparam logic [CfgAddrW-1:0] REG_RADIX   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_SYM_0_3 = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_SYM_4_7 = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SYM_8_B = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_SYM_C_F = 3'd4;

  localparam logic [RadixW-1:0]   RADIX_RST   = 5'd16;
  localparam logic [CfgDataW-1:0] SYM_0_3_RST = 32'h3332_3130;
  localparam logic [CfgDataW-1:0] SYM_4_7_RST = 32'h3736_3534;
  localparam logic [CfgDataW-1:0] SYM_8_B_RST = 32'h4241_3938;
  localparam logic [CfgDataW-1:0] SYM_C_F_RST = 32'h4645_4443;

  localparam logic [CharW-1:0] MINUS_CHAR = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // handed from one cell to the next, registered
  typedef struct packed {
    logic en;
    logic carry;
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> sv/sirt_cell.sv
// ----------------------------------------------------------------------------
// sirt_cell
// One digit of the radix accumulator: doubles its digit, adds the carry of
// its lower neighbor, reduces by the base and passes its own carry upward.
// ----------------------------------------------------------------------------
module sirt_cell
  import sirt_pkg::*;
#(
  parameter int unsigned DIGIT_W = 4,
  parameter int unsigned BASE_W  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [BASE_W-1:0]  base_i,
  input  link_t              link_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output link_t              link_o,
  output logic [DIGIT_W-1:0] digit_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  link_t              link_q, link_d;
  logic [DIGIT_W:0]   sum;
  logic [DIGIT_W:0]   base_ext;
  logic               ge;
  logic [DIGIT_W:0]   red;

  assign sum      = {digit_q, link_i.carry};
  assign base_ext = (DIGIT_W + 1)'(base_i);
  assign ge       = (sum >= base_ext);
  assign red      = ge ? (sum - base_ext) : sum;

  always_comb begin
    digit_d = digit_q;
    link_d  = '0;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else if (link_i.en) begin
      digit_d      = red[DIGIT_W-1:0];
      link_d.en    = 1'b1;
      link_d.carry = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      link_q  <= '0;
    end else begin
      digit_q <= digit_d;
      link_q  <= link_d;
    end
  end

  assign link_o  = link_q;
  assign digit_o = digit_q;

endmodule

>>> sv/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed integer to its text in a configured radix, most
// significant digit first, through a skewed chain of digit cells.
//
//   channel  | dir | payload                        | handshake
//   s_axis   | in  | tdata: number                  | tvalid/tready
//   m_axis   | out | tdata: character, tlast: last  | tvalid/tready
//   cfg      | in  | cfg_addr_i, cfg_wdata_i        | cfg_we_i, no wait
//
// One word at a time. During conversion the magnitude bits enter the cell
// chain MSB first and the carry wavefront crosses all VALUE_BITS cells one
// cell per cycle. Output shifts leading zeros out, one cell per cycle, and
// gives a minus sign first for a negative number; m_axis may stall it. A
// radix below 2 gives the sign alone, if any. No clearing pass after reset.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text
  import sirt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefValueBits,
  parameter int unsigned MAX_RADIX  = DefMaxRadix
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,  // number
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [CharW-1:0]                    m_axis_tdata_o,  // character
  output logic                                m_axis_tlast_o,  // last
  input  logic                                cfg_we_i,
  input  logic [CfgAddrW-1:0]                 cfg_addr_i,
  input  logic [CfgDataW-1:0]                 cfg_wdata_i
);

  localparam int unsigned NCELL     = VALUE_BITS;
  localparam int unsigned DIGIT_W   = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned BASE_W    = DIGIT_W + 1;
  localparam int unsigned CNT_W     = $clog2(2 * VALUE_BITS);
  localparam int unsigned CONV_LAST = VALUE_BITS + NCELL - 2;

  // configuration
  logic [RadixW-1:0]   radix_q;
  logic [CfgDataW-1:0] sym_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RST;
      sym_q[0] <= SYM_0_3_RST;
      sym_q[1] <= SYM_4_7_RST;
      sym_q[2] <= SYM_8_B_RST;
      sym_q[3] <= SYM_C_F_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RADIX:   radix_q  <= cfg_wdata_i[RadixW-1:0];
        REG_SYM_0_3: sym_q[0] <= cfg_wdata_i;
        REG_SYM_4_7: sym_q[1] <= cfg_wdata_i;
        REG_SYM_8_B: sym_q[2] <= cfg_wdata_i;
        REG_SYM_C_F: sym_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control
  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [BASE_W-1:0]     base_q, base_d;
  logic                  lt2_q, lt2_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  cell_ctrl_t            ctrl;
  logic                  feed_en;

  logic [VALUE_BITS-1:0] x_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;

  link_t              lnk   [NCELL+1];
  logic [DIGIT_W-1:0] digit [NCELL];
  logic [DIGIT_W-1:0] top;
  logic [3:0]         sym_idx;

  assign x_in   = s_axis_tdata_i[VALUE_BITS-1:0];
  assign neg_in = x_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (~x_in + VALUE_BITS'(1)) : x_in;
  assign top    = digit[NCELL-1];

  always_comb begin
    state_d         = state_q;
    mag_d           = mag_q;
    cnt_d           = cnt_q;
    base_d          = base_q;
    lt2_d           = lt2_q;
    started_d       = started_q;
    ctrl            = '0;
    feed_en         = 1'b0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    m_axis_tlast_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ctrl.clear = 1'b1;
          mag_d      = mag_in;
          cnt_d      = '0;
          started_d  = 1'b0;
          lt2_d      = (radix_q < RadixW'(2));
          base_d     = (radix_q > RadixW'(MAX_RADIX)) ? BASE_W'(MAX_RADIX)
                                                      : radix_q[BASE_W-1:0];
          if (radix_q < RadixW'(2)) begin
            state_d = neg_in ? ST_SIGN : ST_IDLE;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        feed_en = (cnt_q < CNT_W'(VALUE_BITS));
        if (feed_en) begin
          mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(CONV_LAST)) begin
          cnt_d   = CNT_W'(NCELL - 1);
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SIGN: begin
        m_axis_tvalid_o = 1'b1;
        m_axis_tlast_o  = lt2_q;
        if (m_axis_tready_i) begin
          state_d = lt2_q ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_q && top == '0 && cnt_q != '0) begin
          ctrl.shift = 1'b1;
          cnt_d      = cnt_q - CNT_W'(1);
        end else begin
          m_axis_tvalid_o = 1'b1;
          m_axis_tlast_o  = (cnt_q == '0);
          if (m_axis_tready_i) begin
            started_d = 1'b1;
            if (cnt_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              ctrl.shift = 1'b1;
              cnt_d      = cnt_q - CNT_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign neg_d = (state_q == ST_IDLE && s_axis_tvalid_i) ? neg_in : neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      lt2_q     <= 1'b0;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      base_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      lt2_q     <= lt2_d;
      neg_q     <= neg_d;
      started_q <= started_d;
      base_q    <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  // cell chain
  assign lnk[0].en    = feed_en;
  assign lnk[0].carry = mag_q[VALUE_BITS-1];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [DIGIT_W-1:0] din;
    if (k == 0) begin : g_first
      assign din = '0;
    end else begin : g_rest
      assign din = digit[k-1];
    end
    sirt_cell #(
      .DIGIT_W (DIGIT_W),
      .BASE_W  (BASE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .base_i  (base_q),
      .link_i  (lnk[k]),
      .digit_i (din),
      .link_o  (lnk[k+1]),
      .digit_o (digit[k])
    );
  end

  // symbol lookup
  assign sym_idx = 4'(top);

  always_comb begin
    if (state_q == ST_SIGN) begin
      m_axis_tdata_o = MINUS_CHAR;
    end else begin
      m_axis_tdata_o = sym_q[sym_idx[3:2]][8*sym_idx[1:0] +: CharW];
    end
  end

  // checks
  a_top_no_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lnk[NCELL].en && lnk[NCELL].carry))
    else $error("carry out of the top digit cell");

  a_digit_in_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (BASE_W'(top) < base_q))
    else $error("digit not below base");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while output pending");

  a_conv_feed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && cnt_q == CNT_W'(CONV_LAST)) |-> lnk[NCELL-1].en)
    else $error("conversion wavefront lost");

endmodule
